FILE: rtl/rpn_pkg.sv
package rpn_pkg;

	// Datapath and stack sizing
	localparam int WORD_W      = 32;
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int STEP_W      = $clog2(WORD_W);
	localparam int FUNC_W      = 3;
	localparam int STATUS_W    = 2;

	// Token kinds carried on the input tuser
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH   = 3'd0,
		FUNC_ADD    = 3'd1,
		FUNC_SUB    = 3'd2,
		FUNC_MUL    = 3'd3,
		FUNC_DIV    = 3'd4,
		FUNC_EQUALS = 3'd5
	} func_t;

	// Status codes carried on the output tuser
	typedef enum logic [STATUS_W-1:0] {
		ERR_NONE      = 2'd0,
		ERR_UNDERFLOW = 2'd1,
		ERR_OVERFLOW  = 2'd2,
		ERR_DIVZERO   = 2'd3
	} err_t;

	// Sequencer to arithmetic unit
	typedef struct packed {
		logic              start;
		func_t             kind;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} alu_req_t;

	// Arithmetic unit back to sequencer
	typedef struct packed {
		logic              done;
		logic              div_zero;
		logic [WORD_W-1:0] result;
	} alu_rsp_t;

endpackage

FILE: rtl/rpn_stack.sv
module rpn_stack (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [rpn_pkg::ADDR_W-1:0] wr_addr,
	input  logic [rpn_pkg::WORD_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [rpn_pkg::ADDR_W-1:0] rd_addr,
	output logic [rpn_pkg::WORD_W-1:0] rd_data
);
	import rpn_pkg::*;

	logic [WORD_W-1:0] mem_q [STACK_DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	// Entries below the top of stack
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/rpn_alu.sv
module rpn_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  rpn_pkg::alu_req_t req,
	output rpn_pkg::alu_rsp_t rsp
);
	import rpn_pkg::*;

	typedef enum logic [2:0] {
		A_IDLE,
		A_ADDSUB,
		A_MUL,
		A_DIV,
		A_FIX
	} alu_state_t;

	localparam int SUM_W = WORD_W + 2;

	alu_state_t        state_q;
	logic [WORD_W-1:0] a_q;      // left operand / multiplicand / dividend-quotient
	logic [WORD_W-1:0] b_q;      // right operand / multiplier / divisor
	logic [WORD_W-1:0] acc_q;    // product accumulator
	logic [WORD_W-1:0] rem_q;    // partial remainder
	logic [STEP_W-1:0] step_q;
	logic              sub_q;
	logic              neg_q;
	logic              done_q;
	logic              dz_q;
	logic [WORD_W-1:0] result_q;

	logic [SUM_W-1:0]  add_x;
	logic [SUM_W-1:0]  add_y;
	logic              add_cin;
	logic [SUM_W-1:0]  sum;
	logic [WORD_W:0]   rem_sh;
	logic              last_step;
	logic [WORD_W-1:0] left_abs;
	logic [WORD_W-1:0] right_abs;

	assign rem_sh    = {rem_q, a_q[WORD_W-1]};
	assign last_step = (step_q == STEP_W'(WORD_W - 1));
	assign left_abs  = req.left[WORD_W-1]  ? (~req.left + 1'b1)  : req.left;
	assign right_abs = req.right[WORD_W-1] ? (~req.right + 1'b1) : req.right;

	// Operand select for the one shared adder
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		case (state_q)
			A_ADDSUB: begin
				add_x   = {2'b00, a_q};
				add_y   = sub_q ? ~{2'b00, b_q} : {2'b00, b_q};
				add_cin = sub_q;
			end
			A_MUL: begin
				add_x = {2'b00, acc_q};
				add_y = b_q[0] ? {2'b00, a_q} : '0;
			end
			A_DIV: begin
				add_x   = {1'b0, rem_sh};
				add_y   = ~{2'b00, b_q};
				add_cin = 1'b1;
			end
			default: begin
				add_x = '0;
			end
		endcase
	end

	assign sum = add_x + add_y + SUM_W'(add_cin);

	// Sequencer: add/sub in one pass, shift-add multiply, restoring divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			dz_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						dz_q   <= 1'b0;
						step_q <= '0;
						sub_q  <= (req.kind == FUNC_SUB);
						case (req.kind)
							FUNC_MUL: begin
								a_q     <= req.left;
								b_q     <= req.right;
								acc_q   <= '0;
								state_q <= A_MUL;
							end
							FUNC_DIV: begin
								if (req.right == '0) begin
									result_q <= '0;
									dz_q     <= 1'b1;
									done_q   <= 1'b1;
								end else begin
									a_q     <= left_abs;
									b_q     <= right_abs;
									rem_q   <= '0;
									neg_q   <= req.left[WORD_W-1] ^ req.right[WORD_W-1];
									state_q <= A_DIV;
								end
							end
							default: begin
								a_q     <= req.left;
								b_q     <= req.right;
								state_q <= A_ADDSUB;
							end
						endcase
					end
				end
				A_ADDSUB: begin
					result_q <= sum[WORD_W-1:0];
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				A_MUL: begin
					acc_q  <= sum[WORD_W-1:0];
					a_q    <= {a_q[WORD_W-2:0], 1'b0};
					b_q    <= {1'b0, b_q[WORD_W-1:1]};
					step_q <= step_q + 1'b1;
					if (last_step) begin
						result_q <= sum[WORD_W-1:0];
						done_q   <= 1'b1;
						state_q  <= A_IDLE;
					end
				end
				A_DIV: begin
					// keep the difference only when it did not go negative
					rem_q  <= sum[SUM_W-1] ? rem_sh[WORD_W-1:0] : sum[WORD_W-1:0];
					a_q    <= {a_q[WORD_W-2:0], ~sum[SUM_W-1]};
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					result_q <= neg_q ? (~a_q + 1'b1) : a_q;
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign rsp.result   = result_q;

endmodule

FILE: rtl/rpn_integer_evaluator_core.sv
// Integer RPN evaluator. Each input request is one postfix token: tuser holds the
// token kind (0 push, 1 add, 2 subtract, 3 multiply, 4 divide, 5 equals) and tdata
// the signed 32-bit operand of a push. Operators pop right then left and push the
// wrapped result; divide truncates toward zero and a zero divisor pushes 0. Only
// equals yields an output request: tdata is the top of stack (0 when empty), tuser
// the status (0 ok, 1 underflow, 2 overflow, 3 divide by zero, first error kept);
// the stack and the error are then cleared. Push, equals, rejected operators and
// unused kinds keep the sequencer idle. Operators go through a single shared 34-bit
// adder: add and subtract in one pass, multiply by one shift-add step per bit,
// divide by one restoring step per bit plus a sign fix; the next token is taken
// only when the result is back on the top of stack. The top of stack sits in a
// register, the rest in a 64-entry memory with one registered read port.
// An equals that finds the previous answer still untaken waits for it.
module rpn_integer_evaluator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rpn_pkg::WORD_W-1:0]   s_axis_tdata,  // [31:0] operand_value
	input  logic [rpn_pkg::FUNC_W-1:0]   s_axis_tuser,  // [2:0] func
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [rpn_pkg::WORD_W-1:0]   m_axis_tdata,  // [31:0] answer
	output logic [rpn_pkg::STATUS_W-1:0] m_axis_tuser   // [1:0] status
);
	import rpn_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_WAIT
	} seq_state_t;

	seq_state_t         state_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [WORD_W-1:0]  tos_q;
	err_t               err_q;
	func_t              kind_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_data_q;
	err_t               out_status_q;

	func_t              func;
	logic               accept;
	logic               stack_full;
	logic               has_two;
	logic               is_op;
	logic               mem_wr;
	logic               mem_rd;
	logic [WORD_W-1:0]  mem_rdata;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	err_t               eq_status;

	assign func       = func_t'(s_axis_tuser);
	assign stack_full = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign has_two    = (depth_q >= DEPTH_W'(2));
	assign is_op      = (func == FUNC_ADD) || (func == FUNC_SUB) ||
	                    (func == FUNC_MUL) || (func == FUNC_DIV);

	// Take a token when idle; an equals needs the output slot free
	assign s_axis_tready = (state_q == S_IDLE) &&
	                       !(s_axis_tvalid && (func == FUNC_EQUALS) &&
	                         out_valid_q && !m_axis_tready);
	assign accept = s_axis_tvalid && s_axis_tready;

	// Spill old top on push, fetch left operand on an operator
	assign mem_wr = accept && (func == FUNC_PUSH) && !stack_full && (depth_q != '0);
	assign mem_rd = accept && is_op && has_two;

	rpn_stack u_stack (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (ADDR_W'(depth_q - 1'b1)),
		.wr_data (tos_q),
		.rd_en   (mem_rd),
		.rd_addr (ADDR_W'(depth_q - DEPTH_W'(2))),
		.rd_data (mem_rdata)
	);

	assign alu_req.start = (state_q == S_LOAD);
	assign alu_req.kind  = kind_q;
	assign alu_req.left  = mem_rdata;
	assign alu_req.right = tos_q;

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// Status reported by an equals token
	always_comb begin
		if (err_q != ERR_NONE) begin
			eq_status = err_q;
		end else if (depth_q == '0) begin
			eq_status = ERR_UNDERFLOW;
		end else begin
			eq_status = ERR_NONE;
		end
	end

	// Token sequencer, stack pointer, sticky error and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			err_q       <= ERR_NONE;
			kind_q      <= FUNC_ADD;
			out_valid_q <= 1'b0;
		end else begin
			// Output slot: loaded by an equals, freed when the answer is taken
			if (accept && (func == FUNC_EQUALS)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_PUSH: begin
								if (stack_full) begin
									if (err_q == ERR_NONE) begin
										err_q <= ERR_OVERFLOW;
									end
								end else begin
									tos_q   <= s_axis_tdata;
									depth_q <= depth_q + 1'b1;
								end
							end
							FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
								if (has_two) begin
									kind_q  <= func;
									state_q <= S_LOAD;
								end else if (err_q == ERR_NONE) begin
									err_q <= ERR_UNDERFLOW;
								end
							end
							FUNC_EQUALS: begin
								out_data_q   <= (depth_q == '0) ? '0 : tos_q;
								out_status_q <= eq_status;
								depth_q      <= '0;
								err_q        <= ERR_NONE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LOAD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						tos_q   <= alu_rsp.result;
						depth_q <= depth_q - 1'b1;
						if (alu_rsp.div_zero && (err_q == ERR_NONE)) begin
							err_q <= ERR_DIVZERO;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	// Stack pointer stays within the memory
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// Arithmetic results only arrive while the sequencer waits for them
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_WAIT))
		else $error("arithmetic result outside wait state");

	// An equals request shows up on the output and empties the stack
	a_equals_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_EQUALS)) |=> (m_axis_tvalid && (depth_q == '0)))
		else $error("equals did not produce an output request");

	// An operator with two values leaves the stack one entry shorter on return
	a_op_pops: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WAIT) && alu_rsp.done) |=> (depth_q == $past(depth_q) - 1'b1))
		else $error("operator did not pop one entry");

	// The memory is never read and written in the same cycle
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr && mem_rd))
		else $error("stack memory read and write collide");

endmodule

FILE: dv/tb_rpn_integer_evaluator_core.sv
`timescale 1ns / 100ps

module tb_rpn_integer_evaluator_core;
	import rpn_pkg::*;

	// Kinds outside the token set; the block must ignore them
	localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

	localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [WORD_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;

	// Cycles with no request moving on either side before the run is called hung
	localparam int HANG_LIMIT = 20000;
	// Settle time after the last answer
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [WORD_W-1:0] answer;
		err_t              status;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [WORD_W-1:0]   s_axis_tdata;   // [31:0] operand_value
	logic [FUNC_W-1:0]   s_axis_tuser;   // [2:0] func
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [WORD_W-1:0]   m_axis_tdata;   // [31:0] answer
	logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status

	// Shadow of the evaluator state
	logic [WORD_W-1:0] shadow_stack [STACK_DEPTH];
	int unsigned       shadow_depth;
	err_t              shadow_error;

	answer_t pending_answers [$];
	int      fail_count;
	int      tokens_sent;
	int      hung_cycles;
	int      src_idle_pct;
	int      sink_stall_pct;

	rpn_integer_evaluator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Keeps only the first error since the last equals
	function automatic void note_error(input err_t code);
		if (shadow_error == ERR_NONE) begin
			shadow_error = code;
		end
	endfunction

	// Wrapped 32-bit arithmetic; divide truncates toward zero
	function automatic logic [WORD_W-1:0] combine(input logic [FUNC_W-1:0] kind,
			input logic [WORD_W-1:0] left, input logic [WORD_W-1:0] right);
		longint num;
		longint den;
		longint quo;
		case (kind)
			FUNC_ADD: return left + right;
			FUNC_SUB: return left - right;
			FUNC_MUL: return left * right;
			default: begin
				if (right == '0) begin
					note_error(ERR_DIVZERO);
					return '0;
				end
				num = longint'($signed(left));
				den = longint'($signed(right));
				quo = num / den;
				return quo[WORD_W-1:0];
			end
		endcase
	endfunction

	// Applies one accepted token to the shadow state and queues any answer
	function automatic void evaluate_token(input logic [FUNC_W-1:0] kind,
			input logic [WORD_W-1:0] value);
		answer_t ans;
		case (kind)
			FUNC_PUSH: begin
				if (shadow_depth >= STACK_DEPTH) begin
					note_error(ERR_OVERFLOW);
				end else begin
					shadow_stack[shadow_depth] = value;
					shadow_depth++;
				end
			end
			FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
				if (shadow_depth < 2) begin
					note_error(ERR_UNDERFLOW);
				end else begin
					shadow_stack[shadow_depth-2] = combine(kind,
						shadow_stack[shadow_depth-2], shadow_stack[shadow_depth-1]);
					shadow_depth--;
				end
			end
			FUNC_EQUALS: begin
				ans.answer = '0;
				ans.status = shadow_error;
				if (shadow_depth > 0) begin
					ans.answer = shadow_stack[shadow_depth-1];
				end else if (shadow_error == ERR_NONE) begin
					ans.status = ERR_UNDERFLOW;
				end
				pending_answers.push_back(ans);
				shadow_depth = 0;
				shadow_error = ERR_NONE;
			end
			default: ;
		endcase
	endfunction

	// Operands lean on the corners: zero, +-1, the extremes, small values
	function automatic logic [WORD_W-1:0] pick_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return WORD_NEG1;
			2: return WORD_MIN;
			3: return WORD_MAX;
			4: return 32'd1;
			5, 6: return 32'($urandom_range(0, 400)) - 32'd200;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] pick_operator();
		case ($urandom_range(3))
			0: return FUNC_ADD;
			1: return FUNC_SUB;
			2: return FUNC_MUL;
			default: return FUNC_DIV;
		endcase
	endfunction

	// Sends one token request and updates the shadow once it is taken
	task automatic send_token(input logic [FUNC_W-1:0] kind, input logic [WORD_W-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		evaluate_token(kind, value);
		if (kind <= FUNC_EQUALS) begin
			tokens_sent++;
		end
	endtask

	// Holds the input side until every queued answer has come back
	task automatic wait_answers_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_directed_cases();
		// equals on an empty stack
		send_token(FUNC_EQUALS, 32'h1234_5678);
		// multiply and add both wrap; spare kinds in between change nothing
		send_token(FUNC_PUSH, WORD_MAX);
		send_token(FUNC_PUSH, WORD_MAX);
		send_token(FUNC_MUL, 32'hDEAD_BEEF);
		send_token(FUNC_SPARE_6, 32'hFFFF_FFFF);
		send_token(FUNC_PUSH, WORD_MAX);
		send_token(FUNC_SPARE_7, 32'h0000_0000);
		send_token(FUNC_ADD, 32'h0);
		send_token(FUNC_EQUALS, 32'h0);
		// subtract wraps below the minimum
		send_token(FUNC_PUSH, WORD_MIN);
		send_token(FUNC_PUSH, 32'd1);
		send_token(FUNC_SUB, 32'h0);
		send_token(FUNC_EQUALS, 32'h0);
		// minimum over minus one wraps, no error
		send_token(FUNC_PUSH, WORD_MIN);
		send_token(FUNC_PUSH, WORD_NEG1);
		send_token(FUNC_DIV, 32'h0);
		send_token(FUNC_EQUALS, 32'h0);
		// negative quotient truncates toward zero
		send_token(FUNC_PUSH, -32'sd7);
		send_token(FUNC_PUSH, 32'd2);
		send_token(FUNC_DIV, 32'h0);
		send_token(FUNC_EQUALS, 32'h0);
		// divide by zero, then an underflow that must not replace it
		send_token(FUNC_PUSH, 32'd123);
		send_token(FUNC_PUSH, 32'd0);
		send_token(FUNC_DIV, 32'h0);
		send_token(FUNC_ADD, 32'h0);
		send_token(FUNC_EQUALS, 32'h0);
		// operator on an empty stack, then a value on top
		send_token(FUNC_SUB, 32'h0);
		send_token(FUNC_PUSH, 32'd5);
		send_token(FUNC_EQUALS, 32'h0);
	endtask

	task automatic test_stack_limits();
		// fill, overflow twice, read back the last value kept
		repeat (STACK_DEPTH) send_token(FUNC_PUSH, pick_operand());
		send_token(FUNC_PUSH, WORD_MAX);
		send_token(FUNC_PUSH, WORD_MIN);
		send_token(FUNC_EQUALS, $urandom());
		// fill exactly, then fold the whole stack down
		repeat (STACK_DEPTH) send_token(FUNC_PUSH, $urandom());
		repeat (STACK_DEPTH - 1) send_token(pick_operator(), $urandom());
		send_token(FUNC_EQUALS, $urandom());
	endtask

	// Mostly well-formed expressions with random content, some noise tokens
	task automatic test_random_expressions(input int target);
		int goal;
		int operands;
		int pushed;
		int live;
		bit push_first;
		int quirk;
		goal = tokens_sent + target;
		while (tokens_sent < goal) begin
			if ($urandom_range(99) < 12) begin
				send_token(3'($urandom_range(7)), $urandom());
			end else begin
				push_first = ($urandom_range(15) == 0);
				operands = push_first ? $urandom_range(2, STACK_DEPTH + 2) : $urandom_range(1, 6);
				pushed = 0;
				live = 0;
				while (pushed < operands || live > 1) begin
					if (pushed < operands && (live < 2 || push_first || $urandom_range(1) == 0)) begin
						send_token(FUNC_PUSH, pick_operand());
						pushed++;
						if (live < STACK_DEPTH) begin
							live++;
						end
					end else begin
						send_token(pick_operator(), $urandom());
						live--;
					end
				end
				// now and then one operator too many, or a value left over
				quirk = $urandom_range(9);
				if (quirk == 0) begin
					send_token(pick_operator(), $urandom());
				end else if (quirk == 1) begin
					send_token(FUNC_PUSH, pick_operand());
				end
				send_token(FUNC_EQUALS, $urandom());
				if ($urandom_range(39) == 0) begin
					wait_answers_drained();
				end
			end
		end
	endtask

	task automatic test_sender_pause();
		send_token(FUNC_PUSH, pick_operand());
		send_token(FUNC_PUSH, pick_operand());
		send_token(FUNC_DIV, $urandom());
		send_token(FUNC_EQUALS, $urandom());
		wait_answers_drained();
		send_token(FUNC_EQUALS, $urandom());
	endtask

	// Output side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Compare each answer request with the oldest prediction
	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected answer %h status %0d", m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (m_axis_tdata !== want.answer) begin
					$error("answer: expected %h, got %h", want.answer, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// Hang detector
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			hung_cycles = 0;
		end else begin
			hung_cycles++;
		end
		if (hung_cycles >= HANG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		fail_count     = 0;
		tokens_sent    = 0;
		hung_cycles    = 0;
		shadow_depth   = 0;
		shadow_error   = ERR_NONE;
		src_idle_pct   = 10;
		sink_stall_pct = 80;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= FUNC_PUSH;
		m_axis_tready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver mostly stalled
		test_directed_cases();
		test_stack_limits();
		test_random_expressions(440);

		// sender mostly idle, receiver mostly ready
		src_idle_pct   = 80;
		sink_stall_pct = 10;
		test_sender_pause();
		test_random_expressions(440);

		// full rate both sides
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		test_random_expressions(440);

		wait_answers_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
